// ===== src/pstc_pkg.sv =====
// Package for the PID speed-to-throttle controller.
// Field widths, register reset values, register index codes and action codes.
// No dependencies.
package pstc_pkg;

  localparam int MAX_ENGINES_DEFAULT = 8;

  localparam int GAIN_W   = 24;
  localparam int TIME_W   = 24;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 17;
  localparam int INTEG_W  = 48;
  localparam int LEVEL_W  = 16;
  localparam int ENG_IN_W = 8;
  localparam int ENG_W    = 4;

  localparam logic signed [GAIN_W-1:0] PGAIN_RESET = 24'sd3277;
  localparam logic signed [GAIN_W-1:0] IGAIN_RESET = 24'sd1311;
  localparam logic signed [GAIN_W-1:0] DGAIN_RESET = 24'sd655;
  localparam logic [TIME_W-1:0]        DINT_RESET  = 24'd104858;

  typedef enum logic [1:0] {
    REG_PGAIN = 2'd0,
    REG_IGAIN = 2'd1,
    REG_DGAIN = 2'd2,
    REG_DINT  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_ENGAGE    = 2'd1,
    ACT_DISENGAGE = 2'd2,
    ACT_UNUSED    = 2'd3
  } action_t;

endpackage

// ===== src/pid_speed_throttle_controller.sv =====
// PID speed-to-throttle regulator, top level.
// Uses pstc_pkg for widths, reset values and codes.
//
// An engage or disengage item clears the integral and the previous error and
// returns one result with the new override flag through the output step.
// A tick while engaged returns a throttle command after a multiply of error by
// elapsed time, the saturating integral update, the restoring divider for the
// derivative (one quotient bit per cycle), the proportional, integral and two
// derivative products and the output step, which folds in the last product;
// all five products use the single shared 25x29 signed multiplier and its
// product register. A tick while disengaged, or an unused action code, is
// dropped. in_stall is high from acceptance until the item is finished; a
// finished result waits in the output register while the next item is taken,
// and the output step holds only while that register is full and stalled.
module pid_speed_throttle_controller
  import pstc_pkg::*;
#(
  parameter int MAX_ENGINES = MAX_ENGINES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [SPEED_W-1:0]   target_speed,
  input  logic [SPEED_W-1:0]   current_speed,
  input  logic [TIME_W-1:0]    elapsed_time,
  input  logic [ENG_IN_W-1:0]  engine_count,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 throttle_valid,
  output logic [LEVEL_W-1:0]   throttle_level,
  output logic [ENG_W-1:0]     engines_driven,
  output logic                 override_active
);

  localparam int DIV_STEPS = 37;            // 17 bit |diff| followed by 20 zero bits
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int MA_W      = 25;
  localparam int MB_W      = 29;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int SUM_W     = 64;
  localparam int DRV_W     = 38;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MI   = 9'b000000010,
    S_IU   = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MP   = 9'b000010000,
    S_MINT = 9'b000100000,
    S_MDL  = 9'b001000000,
    S_MDH  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic signed [GAIN_W-1:0] pgain, igain, dgain;
  logic [TIME_W-1:0]        dint;

  logic                      enabled;
  logic signed [INTEG_W-1:0] integral;
  logic signed [ERR_W-1:0]   prev_err;

  logic signed [ERR_W-1:0]  err;
  logic [TIME_W-1:0]        dt;
  logic [ENG_W-1:0]         eng;
  logic                     is_tick;
  logic                     diff_neg;
  logic [DIV_STEPS-1:0]     dvd;
  logic [TIME_W-1:0]        rem;
  logic [CNT_W-1:0]         cnt;
  logic                     acc_hi;       // product register holds the high derivative part
  logic signed [DRV_W-1:0]  deriv;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  logic in_fire;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pgain <= PGAIN_RESET;
      igain <= IGAIN_RESET;
      dgain <= DGAIN_RESET;
      dint  <= DINT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PGAIN: pgain <= cfg_data;
        REG_IGAIN: igain <= cfg_data;
        REG_DGAIN: dgain <= cfg_data;
        REG_DINT:  dint  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input-side arithmetic, used at acceptance
  logic signed [ERR_W-1:0] err_in;
  logic signed [ERR_W:0]   diff_in;
  logic signed [ERR_W:0]   diff_abs;
  logic [TIME_W-1:0]       dt_in;
  logic [ENG_W-1:0]        eng_in;

  always_comb begin
    err_in   = $signed({1'b0, target_speed}) - $signed({1'b0, current_speed});
    diff_in  = {err_in[ERR_W-1], err_in} - {prev_err[ERR_W-1], prev_err};
    diff_abs = diff_in[ERR_W] ? -diff_in : diff_in;
    if (elapsed_time != '0) begin
      dt_in = elapsed_time;
    end else if (dint != '0) begin
      dt_in = dint;
    end else begin
      dt_in = TIME_W'(1);
    end
    if (engine_count == '0 || engine_count > ENG_IN_W'(MAX_ENGINES)) begin
      eng_in = ENG_W'(MAX_ENGINES);
    end else begin
      eng_in = engine_count[ENG_W-1:0];
    end
  end

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MI: begin
        mul_a = $signed({1'b0, dt});
        mul_b = MB_W'(err);
      end
      S_MP: begin
        mul_a = MA_W'(pgain);
        mul_b = MB_W'(err);
      end
      S_MINT: begin
        mul_a = MA_W'(igain);
        mul_b = MB_W'($signed(integral[INTEG_W-1:20]));
      end
      S_MDL: begin
        mul_a = MA_W'(dgain);
        mul_b = $signed({10'b0, deriv[18:0]});
      end
      S_MDH: begin
        mul_a = MA_W'(dgain);
        mul_b = MB_W'($signed(deriv[DRV_W-1:19]));
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // saturating integral update
  logic signed [INTEG_W:0] integ_ext;
  always_comb begin
    integ_ext = {integral[INTEG_W-1], integral} + {{8{prod[40]}}, prod[40:0]};
  end

  // divider step
  logic [TIME_W:0] trial;
  logic            q_bit;
  always_comb begin
    trial = {rem, dvd[DIV_STEPS-1]};
    q_bit = (trial >= {1'b0, dt});
  end

  // product as a sum term; the high derivative part carries a 2^19 weight
  logic signed [SUM_W-1:0] prod_term;
  always_comb begin
    if (acc_hi) begin
      prod_term = {prod[44:0], 19'b0};
    end else begin
      prod_term = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          priority if (action == ACT_ENGAGE || action == ACT_DISENGAGE) begin
            state_next = S_OUT;
          end else if (action == ACT_TICK && enabled) begin
            state_next = S_MI;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_MI:   state_next = S_IU;
      S_IU:   state_next = S_DIV;
      S_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_MP;
      S_MP:   state_next = S_MINT;
      S_MINT: state_next = S_MDL;
      S_MDL:  state_next = S_MDH;
      S_MDH:  state_next = S_OUT;
      S_OUT:  if (out_free && !acc_hi) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      enabled  <= 1'b0;
      integral <= '0;
      prev_err <= '0;
      acc_hi   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (action == ACT_ENGAGE || action == ACT_DISENGAGE) begin
          enabled  <= (action == ACT_ENGAGE);
          integral <= '0;
          prev_err <= '0;
        end else if (action == ACT_TICK && enabled) begin
          prev_err <= err_in;
        end
      end
      if (state == S_IU) begin
        if (integ_ext[INTEG_W] != integ_ext[INTEG_W-1]) begin
          integral <= integ_ext[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integral <= integ_ext[INTEG_W-1:0];
        end
      end
      // last product is folded in on the first cycle of the output step
      if (state == S_MDH) begin
        acc_hi <= 1'b1;
      end else if (state == S_OUT) begin
        acc_hi <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err      <= err_in;
      dt       <= dt_in;
      eng      <= eng_in;
      is_tick  <= (action == ACT_TICK);
      diff_neg <= diff_in[ERR_W];
      dvd      <= {diff_abs[ERR_W-1:0], 20'b0};
      rem      <= '0;
      cnt      <= '0;
    end
    if (state == S_DIV) begin
      rem <= q_bit ? TIME_W'(trial - {1'b0, dt}) : trial[TIME_W-1:0];
      dvd <= {dvd[DIV_STEPS-2:0], q_bit};
      cnt <= cnt + CNT_W'(1);
    end
    if (state == S_MP) begin
      deriv <= diff_neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
    end
    if (state == S_MI || state == S_MP || state == S_MINT || state == S_MDL ||
        state == S_MDH) begin
      prod <= mul_p;
    end
    if (state == S_MINT) begin
      sum <= prod_term;
    end else if (state == S_MDL || state == S_MDH || (state == S_OUT && acc_hi)) begin
      sum <= sum + prod_term;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free && !acc_hi) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free && !acc_hi) begin
      throttle_valid  <= is_tick;
      engines_driven  <= is_tick ? eng : '0;
      override_active <= enabled;
      if (!is_tick || sum <= 0) begin
        throttle_level <= '0;
      end else if (sum >= SUM_W'(64'sd4194304)) begin
        throttle_level <= '1;
      end else begin
        throttle_level <= sum[21:6];
      end
    end
  end

endmodule

// ===== src/pstc_checker.sv =====
// Port-level checks for the PID speed-to-throttle controller.
// Attached to pid_speed_throttle_controller by the bind at the end.
module pstc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        throttle_valid,
  input logic [15:0] throttle_level,
  input logic [3:0]  engines_driven,
  input logic        override_active
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(throttle_level) &&
      $stable(throttle_valid) && $stable(engines_driven) && $stable(override_active))
    else $error("stalled result item changed");

  // engage and disengage items carry no command
  a_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !throttle_valid |-> throttle_level == 16'd0 && engines_driven == 4'd0)
    else $error("non-command item carries throttle fields");

  // a throttle command only comes while engaged
  a_cmd_engaged: assert property (@(posedge clk) disable iff (rst)
    out_valid && throttle_valid |-> override_active)
    else $error("throttle command while disengaged");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  // handshake lines are never unknown once out of reset
  a_hs_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_stall, out_valid, out_stall}))
    else $error("handshake line unknown");

endmodule

bind pid_speed_throttle_controller pstc_checker u_pstc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .throttle_valid  (throttle_valid),
  .throttle_level  (throttle_level),
  .engines_driven  (engines_driven),
  .override_active (override_active)
);
